### rtl/vpth_pkg.sv
// Package for the vertical point-in-triangle height unit.
// Holds shared widths, defaults and the word type passed from front to back.
// No dependencies.
package vpth_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int IW              = 32;
    localparam int EW              = 33;
    localparam int NW              = 66;
    localparam int MGW             = 16;
    localparam logic [MGW-1:0] MARGIN_RESET = 16'd13107;

    typedef struct packed {
        logic signed [NW-1:0] d;
        logic signed [NW-1:0] ns;
        logic signed [NW-1:0] nt;
        logic signed [EW-1:0] e1y;
        logic signed [EW-1:0] e2y;
        logic signed [IW-1:0] y0;
    } t_tri;

    localparam int TRI_W = $bits(t_tri);

endpackage

### rtl/vertical_point_in_triangle_height_unit.sv
// Top level of the vertical point-in-triangle height unit.
// Instantiates vpth_front, vpth_fifo and vpth_back; holds the margin register. Uses vpth_pkg.
//
// Channel   Handshake              Words
// input     push / full            triangle vertices and player position
// result    empty / pop            inside flag, degenerate flag, height
// config    cfg_valid / cfg_ready  margin, Q0.16
//
// The front end accepts a word, forms its products on its multiplier and then hands
// the word on, waiting while the queue is full. The back end's time is set by the
// shared divider. A degenerate triangle skips the divider and goes straight to the
// output state.
// Reset is synchronous and clears the held height to zero and margin to 0.2.
// A full result register stalls the back end; the queue lets the front end keep going.
module vertical_point_in_triangle_height_unit import vpth_pkg::*; #(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [IW-1:0] i_v0_x,
    input  logic signed [IW-1:0] i_v0_y,
    input  logic signed [IW-1:0] i_v0_z,
    input  logic signed [IW-1:0] i_v1_x,
    input  logic signed [IW-1:0] i_v1_y,
    input  logic signed [IW-1:0] i_v1_z,
    input  logic signed [IW-1:0] i_v2_x,
    input  logic signed [IW-1:0] i_v2_y,
    input  logic signed [IW-1:0] i_v2_z,
    input  logic signed [IW-1:0] i_player_x,
    input  logic signed [IW-1:0] i_player_y,
    input  logic signed [IW-1:0] i_player_z,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_inside_res,
    output logic                 o_degenerate,
    output logic signed [IW-1:0] o_height,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [MGW-1:0]       i_cfg_data
);

    logic [MGW-1:0] r_margin;
    logic w_wr, w_q_full, w_q_empty, w_q_pop;
    logic w_unused;
    t_tri w_wr_word, w_rd_word;

    assign o_cfg_ready = 1'b1;
    assign w_unused    = ^i_player_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready && !w_unused | i_cfg_valid) begin
            r_margin <= i_cfg_data;
        end
    end

    vpth_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_v0_x     (i_v0_x),
        .i_v0_y     (i_v0_y),
        .i_v0_z     (i_v0_z),
        .i_v1_x     (i_v1_x),
        .i_v1_y     (i_v1_y),
        .i_v1_z     (i_v1_z),
        .i_v2_x     (i_v2_x),
        .i_v2_y     (i_v2_y),
        .i_v2_z     (i_v2_z),
        .i_player_x (i_player_x),
        .i_player_z (i_player_z),
        .o_wr       (w_wr),
        .o_word     (w_wr_word),
        .i_q_full   (w_q_full)
    );

    vpth_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_word  (w_wr_word),
        .o_full  (w_q_full),
        .i_rd    (w_q_pop),
        .o_word  (w_rd_word),
        .o_empty (w_q_empty)
    );

    vpth_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .i_q_word     (w_rd_word),
        .o_q_pop      (w_q_pop),
        .i_margin     (r_margin),
        .empty        (empty),
        .pop          (pop),
        .o_inside_res (o_inside_res),
        .o_degenerate (o_degenerate),
        .o_height     (o_height)
    );

endmodule

### rtl/vpth_front.sv
// Front end: accepts one triangle word and forms the determinant and the two numerators.
// One shared 33 by 33 multiplier runs six products in sequence. Depends on vpth_pkg.
module vpth_front import vpth_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [IW-1:0] i_v0_x,
    input  logic signed [IW-1:0] i_v0_y,
    input  logic signed [IW-1:0] i_v0_z,
    input  logic signed [IW-1:0] i_v1_x,
    input  logic signed [IW-1:0] i_v1_y,
    input  logic signed [IW-1:0] i_v1_z,
    input  logic signed [IW-1:0] i_v2_x,
    input  logic signed [IW-1:0] i_v2_y,
    input  logic signed [IW-1:0] i_v2_z,
    input  logic signed [IW-1:0] i_player_x,
    input  logic signed [IW-1:0] i_player_z,
    output logic                 o_wr,
    output t_tri                 o_word,
    input  logic                 i_q_full
);

    typedef enum logic [2:0] {
        FS_IDLE = 3'b001,
        FS_MUL  = 3'b010,
        FS_PUSH = 3'b100
    } t_fstate;

    t_fstate r_state;
    logic [2:0] r_cnt;
    logic signed [EW-1:0] r_e1x, r_e1z, r_e2x, r_e2z, r_bx, r_bz;
    logic signed [NW-1:0] r_p;
    t_tri r_word;
    logic signed [EW-1:0] w_ma, w_mb;
    logic signed [NW-1:0] w_prod;

    always_comb begin
        case (r_cnt)
            3'd0: begin w_ma = r_e2x; w_mb = r_e1z; end
            3'd1: begin w_ma = r_e1x; w_mb = r_e2z; end
            3'd2: begin w_ma = r_e2x; w_mb = r_bz; end
            3'd3: begin w_ma = r_e2z; w_mb = r_bx; end
            3'd4: begin w_ma = r_e1z; w_mb = r_bx; end
            3'd5: begin w_ma = r_e1x; w_mb = r_bz; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign full   = (r_state != FS_IDLE);
    assign o_wr   = (r_state == FS_PUSH) && !i_q_full;
    assign o_word = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                FS_IDLE: begin
                    if (push) begin
                        r_e1x <= EW'(i_v1_x) - EW'(i_v0_x);
                        r_e1z <= EW'(i_v1_z) - EW'(i_v0_z);
                        r_e2x <= EW'(i_v2_x) - EW'(i_v0_x);
                        r_e2z <= EW'(i_v2_z) - EW'(i_v0_z);
                        r_bx  <= EW'(i_player_x) - EW'(i_v0_x);
                        r_bz  <= EW'(i_player_z) - EW'(i_v0_z);
                        r_word.e1y <= EW'(i_v1_y) - EW'(i_v0_y);
                        r_word.e2y <= EW'(i_v2_y) - EW'(i_v0_y);
                        r_word.y0  <= i_v0_y;
                        r_cnt   <= '0;
                        r_state <= FS_MUL;
                    end
                end
                FS_MUL: begin
                    r_p <= w_prod;
                    case (r_cnt)
                        3'd1: r_word.d  <= r_p;
                        3'd2: r_word.d  <= r_word.d - r_p;
                        3'd3: r_word.ns <= r_p;
                        3'd4: r_word.ns <= r_word.ns - r_p;
                        3'd5: r_word.nt <= r_p;
                        3'd6: r_word.nt <= r_word.nt - r_p;
                        default: ;
                    endcase
                    if (r_cnt == 3'd6) begin
                        r_state <= FS_PUSH;
                    end
                    r_cnt <= r_cnt + 3'd1;
                end
                FS_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= FS_IDLE;
                    end
                end
                default: r_state <= FS_IDLE;
            endcase
        end
    end

endmodule

### rtl/vpth_fifo.sv
// Short queue of triangle words between the front end and the back end.
// Register based, one read place at the head. Depends on vpth_pkg.
module vpth_fifo import vpth_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_tri i_word,
    output logic o_full,
    input  logic i_rd,
    output t_tri o_word,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_tri r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(w_wr) - CW'(w_rd);
        end
    end

endmodule

### rtl/vpth_back.sv
// Back end: divides both numerators by the determinant, tests the range, interpolates.
// One iterative restoring divider and one multiplier; holds the height. Depends on vpth_pkg.
module vpth_back import vpth_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  t_tri                 i_q_word,
    output logic                 o_q_pop,
    input  logic [MGW-1:0]       i_margin,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_inside_res,
    output logic                 o_degenerate,
    output logic signed [IW-1:0] o_height
);

    localparam int QW = FRAC_BITS + 6;
    localparam int UW = FRAC_BITS + 5;
    localparam int MW = NW - 1;
    localparam int RW = MW + FRAC_BITS + 4;
    localparam int HW = FRAC_BITS + 40;
    localparam int CW = $clog2(FRAC_BITS + 5);
    localparam logic signed [HW-1:0] SMAX = {{(HW-IW){1'b0}}, 1'b0, {(IW-1){1'b1}}};
    localparam logic signed [HW-1:0] SMIN = {{(HW-IW){1'b1}}, 1'b1, {(IW-1){1'b0}}};

    typedef enum logic [6:0] {
        BS_IDLE = 7'b0000001,
        BS_DSET = 7'b0000010,
        BS_DIV  = 7'b0000100,
        BS_MS   = 7'b0001000,
        BS_MT   = 7'b0010000,
        BS_SUM  = 7'b0100000,
        BS_OUT  = 7'b1000000
    } t_bstate;

    t_bstate r_state;
    t_tri r_word;
    logic r_sel, r_neg, r_degen, r_ov;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_rem, r_ds;
    logic [UW-1:0] r_q;
    logic signed [QW-1:0] r_s, r_t;
    logic signed [HW-1:0] r_p, r_h;
    logic signed [IW-1:0] r_held;
    logic r_out_in, r_out_dg;
    logic signed [IW-1:0] r_out_h;

    logic signed [NW-1:0] w_num, w_nneg, w_dneg;
    logic [MW-1:0] w_nabs, w_dabs;
    logic w_big;
    logic signed [QW-1:0] w_qs, w_mf, w_hi, w_ma;
    logic signed [EW-1:0] w_mb;
    logic signed [HW-1:0] w_prod, w_hr, w_sat;
    logic [FRAC_BITS+MGW-1:0] w_mfull;
    logic w_inside;
    logic w_load;

    assign w_num  = r_sel ? r_word.nt : r_word.ns;
    assign w_nneg = -w_num;
    assign w_dneg = -r_word.d;
    assign w_nabs = w_num[NW-1] ? w_nneg[MW-1:0] : w_num[MW-1:0];
    assign w_dabs = r_word.d[NW-1] ? w_dneg[MW-1:0] : r_word.d[MW-1:0];
    assign w_big  = ({4'b0, w_nabs} >= {w_dabs, 4'b0});
    assign w_qs   = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

    assign w_mfull = {i_margin, {FRAC_BITS{1'b0}}};
    assign w_mf    = $signed(QW'(w_mfull[FRAC_BITS+MGW-1:MGW]));
    assign w_hi    = $signed(QW'(1) <<< FRAC_BITS) + w_mf;
    assign w_inside = !r_degen && (r_s >= -w_mf) && (r_s <= w_hi)
                      && (r_t >= -w_mf) && (r_t <= w_hi);

    assign w_ma   = (r_state == BS_MS) ? r_s : r_t;
    assign w_mb   = (r_state == BS_MS) ? r_word.e1y : r_word.e2y;
    assign w_prod = w_ma * w_mb;

    assign w_hr  = (r_h + (HW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign w_sat = (w_hr > SMAX) ? SMAX : ((w_hr < SMIN) ? SMIN : w_hr);

    assign w_load       = (r_state == BS_OUT) && (!r_ov || pop);
    assign o_q_pop      = (r_state == BS_IDLE) && !i_q_empty;
    assign empty        = !r_ov;
    assign o_inside_res = r_out_in;
    assign o_degenerate = r_out_dg;
    assign o_height     = r_out_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_ov    <= 1'b0;
            r_held  <= '0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (pop) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                BS_IDLE: begin
                    if (!i_q_empty) begin
                        r_word  <= i_q_word;
                        r_sel   <= 1'b0;
                        r_degen <= (i_q_word.d == '0);
                        r_state <= (i_q_word.d == '0) ? BS_OUT : BS_DSET;
                    end
                end
                BS_DSET: begin
                    r_neg <= w_num[NW-1] ^ r_word.d[NW-1];
                    r_rem <= RW'(w_nabs) << FRAC_BITS;
                    r_ds  <= RW'(w_dabs) << (FRAC_BITS + 3);
                    if (w_big) begin
                        r_q   <= UW'(1) << (FRAC_BITS + 4);
                        r_cnt <= '0;
                    end else begin
                        r_q   <= '0;
                        r_cnt <= CW'(FRAC_BITS + 4);
                    end
                    r_state <= BS_DIV;
                end
                BS_DIV: begin
                    if (r_cnt == '0) begin
                        if (r_sel) begin
                            r_t     <= w_qs;
                            r_state <= BS_MS;
                        end else begin
                            r_s     <= w_qs;
                            r_sel   <= 1'b1;
                            r_state <= BS_DSET;
                        end
                    end else begin
                        if (r_rem >= r_ds) begin
                            r_rem <= r_rem - r_ds;
                            r_q   <= {r_q[UW-2:0], 1'b1};
                        end else begin
                            r_q   <= {r_q[UW-2:0], 1'b0};
                        end
                        r_ds  <= r_ds >> 1;
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                BS_MS: begin
                    r_p     <= w_prod;
                    r_state <= BS_MT;
                end
                BS_MT: begin
                    r_h     <= (HW'(r_word.y0) <<< FRAC_BITS) + r_p;
                    r_p     <= w_prod;
                    r_state <= BS_SUM;
                end
                BS_SUM: begin
                    r_h     <= r_h + r_p;
                    r_state <= BS_OUT;
                end
                BS_OUT: begin
                    if (w_load) begin
                        r_out_in <= w_inside;
                        r_out_dg <= r_degen;
                        if (w_inside) begin
                            r_held  <= w_sat[IW-1:0];
                            r_out_h <= w_sat[IW-1:0];
                        end else begin
                            r_out_h <= r_held;
                        end
                        r_state <= BS_IDLE;
                    end
                end
                default: r_state <= BS_IDLE;
            endcase
        end
    end

endmodule

### tb/testbench.sv
// Testbench for the vertical point-in-triangle height unit.
// It predicts each result with its own fixed point triangle solver and checks
// every popped word against it. Depends on vpth_pkg and the unit's RTL.
module testbench;
    import vpth_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 80;

    localparam int V0X = 0, V0Y = 1, V0Z = 2, V1X = 3, V1Y = 4, V1Z = 5;
    localparam int V2X = 6, V2Y = 7, V2Z = 8, PX = 9, PY = 10, PZ = 11;
    localparam int NFIELD = 12;

    typedef logic signed [IW-1:0] t_word;
    typedef t_word t_item [NFIELD];

    typedef struct {
        logic  in_tri;
        logic  degen;
        t_word height;
    } t_height_res;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           push = 1'b0;
    logic           full;
    t_word          fld [NFIELD];
    logic           empty;
    logic           pop = 1'b0;
    logic           o_inside_res;
    logic           o_degenerate;
    t_word          o_height;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [MGW-1:0] i_cfg_data = '0;

    t_height_res    expected_heights [$];
    logic [MGW-1:0] margin_shadow = MARGIN_RESET;
    t_word          held_shadow = '0;
    int             mismatches = 0;
    int             hold_pop_cycles = 0;
    int             idle_cycles = 0;
    logic           pop_enable = 1'b0;

    initial begin
        for (int i = 0; i < NFIELD; i++) begin
            fld[i] = '0;
        end
    end

    vertical_point_in_triangle_height_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_v0_x(fld[V0X]), .i_v0_y(fld[V0Y]), .i_v0_z(fld[V0Z]),
        .i_v1_x(fld[V1X]), .i_v1_y(fld[V1Y]), .i_v1_z(fld[V1Z]),
        .i_v2_x(fld[V2X]), .i_v2_y(fld[V2Y]), .i_v2_z(fld[V2Z]),
        .i_player_x(fld[PX]), .i_player_y(fld[PY]), .i_player_z(fld[PZ]),
        .empty(empty), .pop(pop),
        .o_inside_res(o_inside_res), .o_degenerate(o_degenerate), .o_height(o_height),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint edge_quotient(logic signed [79:0] num, logic signed [79:0] den);
        logic [99:0] an, ad;
        longint q;
        an = num < 0 ? 100'(-num) : 100'(num);
        ad = den < 0 ? 100'(-den) : 100'(den);
        if (an >= (ad << 4)) begin
            q = longint'(1) << (FB + 4);
        end else begin
            q = longint'((an << FB) / ad);
        end
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic t_height_res predict_height(t_item it);
        logic signed [79:0] y0, e1x, e1y, e1z, e2x, e2y, e2z, bx, bz;
        logic signed [79:0] d, ns, nt, s, t, mf, hiv, h, r;
        t_height_res res;
        y0  = it[V0Y];
        e1x = it[V1X] - 80'(it[V0X]);
        e1y = it[V1Y] - 80'(it[V0Y]);
        e1z = it[V1Z] - 80'(it[V0Z]);
        e2x = it[V2X] - 80'(it[V0X]);
        e2y = it[V2Y] - 80'(it[V0Y]);
        e2z = it[V2Z] - 80'(it[V0Z]);
        bx  = it[PX] - 80'(it[V0X]);
        bz  = it[PZ] - 80'(it[V0Z]);
        d   = e2x * e1z - e1x * e2z;
        res.in_tri = 1'b0;
        res.degen  = 1'b0;
        if (d == 0) begin
            res.degen = 1'b1;
        end else begin
            ns  = e2x * bz - e2z * bx;
            nt  = e1z * bx - e1x * bz;
            s   = edge_quotient(ns, d);
            t   = edge_quotient(nt, d);
            mf  = 80'(margin_shadow);
            hiv = (80'sd1 <<< FB) + mf;
            if (s >= -mf && s <= hiv && t >= -mf && t <= hiv) begin
                h = (y0 <<< FB) + s * e1y + t * e2y;
                r = (h + (80'sd1 <<< (FB - 1))) >>> FB;
                if (r > 80'sd2147483647) r = 80'sd2147483647;
                if (r < -80'sd2147483648) r = -80'sd2147483648;
                held_shadow = t_word'(r);
                res.in_tri = 1'b1;
            end
        end
        res.height = held_shadow;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic send_item(t_item it, bit gaps);
        int gap;
        logic was_full;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        for (int i = 0; i < NFIELD; i++) begin
            fld[i] <= it[i];
        end
        do begin
            @(negedge i_clk);
            was_full = full;
            @(posedge i_clk);
        end while (was_full);
        expected_heights.insert(expected_heights.size(), predict_height(it));
    endtask

    task automatic stop_sending();
        push <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (expected_heights.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_margin(logic [MGW-1:0] value);
        logic was_ready;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            was_ready = o_cfg_ready;
            @(posedge i_clk);
        end while (!was_ready);
        i_cfg_valid <= 1'b0;
        margin_shadow = value;
    endtask

    // A triangle around a random origin with the player placed at chosen
    // edge coordinates, so most of them land near the tolerant range.
    function automatic t_item shaped_item();
        t_item it;
        longint x0, z0, e1x, e1z, e2x, e2z, a, b;
        int sh;
        for (int i = 0; i < NFIELD; i++) begin
            it[i] = $urandom;
        end
        sh  = $urandom_range(24, 2);
        x0  = $signed($urandom) >>> $urandom_range(16, 4);
        z0  = $signed($urandom) >>> $urandom_range(16, 4);
        e1x = $signed($urandom) >>> (32 - sh);
        e1z = $signed($urandom) >>> (32 - sh);
        e2x = $signed($urandom) >>> (32 - sh);
        e2z = $signed($urandom) >>> (32 - sh);
        a   = longint'($urandom_range(110000)) - 22000;
        b   = longint'($urandom_range(110000)) - 22000;
        it[V0X] = t_word'(x0);
        it[V0Z] = t_word'(z0);
        it[V1X] = t_word'(x0 + e1x);
        it[V1Z] = t_word'(z0 + e1z);
        it[V2X] = t_word'(x0 + e2x);
        it[V2Z] = t_word'(z0 + e2z);
        it[PX]  = t_word'(x0 + ((e1x * a + e2x * b) >>> 16));
        it[PZ]  = t_word'(z0 + ((e1z * a + e2z * b) >>> 16));
        if ($urandom_range(3) != 0) begin
            it[V0Y] = $signed($urandom) >>> $urandom_range(12, 0);
            it[V1Y] = $signed($urandom) >>> $urandom_range(12, 0);
            it[V2Y] = $signed($urandom) >>> $urandom_range(12, 0);
        end
        if ($urandom_range(19) == 0) begin
            it[V2X] = it[V1X];
            it[V2Z] = it[V1Z];
        end
        return it;
    endfunction

    function automatic t_item random_item();
        t_item it;
        if ($urandom_range(9) < 8) return shaped_item();
        for (int i = 0; i < NFIELD; i++) begin
            it[i] = $urandom;
        end
        return it;
    endfunction

    function automatic t_item make_item(t_word x0, t_word y0, t_word z0, t_word x1, t_word y1,
                                        t_word z1, t_word x2, t_word y2, t_word z2,
                                        t_word px, t_word pz);
        t_item it;
        it = '{x0, y0, z0, x1, y1, z1, x2, y2, z2, px, t_word'($urandom), pz};
        return it;
    endfunction

    task automatic test_directed();
        t_item it;
        t_word one, mx, mn;
        one = 32'sh0001_0000;
        mx  = 32'sh7FFF_FFFF;
        mn  = 32'sh8000_0000;
        send_item(make_item(0, one, 0, one, 2 * one, 0, 0, 3 * one, one, one / 4, one / 4), 0);
        send_item(make_item(0, one, 0, one, 2 * one, 0, 0, 3 * one, one, 0, 0), 0);
        send_item(make_item(0, one, 0, one, 2 * one, 0, 0, 3 * one, one, one, one), 0);
        send_item(make_item(0, 0, 0, one, one, 0, 0, one, one, -13107, 0), 0);
        send_item(make_item(0, 0, 0, one, one, 0, 0, one, one, -13108, 0), 0);
        send_item(make_item(0, 0, 0, one, one, 0, 0, one, one, 78643, 0), 0);
        send_item(make_item(0, 0, 0, one, one, 0, 0, one, one, 78644, 0), 0);
        send_item(make_item(0, 5, 0, 0, 9, 0, 0, 7, 0, one, one), 0);
        send_item(make_item(one, 0, one, one, 0, one, one, 0, one, 0, 0), 0);
        send_item(make_item(0, 0, 0, 1, 0, 0, 0, 0, 1, mx, mn), 0);
        send_item(make_item(0, mx, 0, one, mx, 0, 0, mn, one, one / 2, one), 0);
        send_item(make_item(0, mn, 0, one, mn, 0, 0, mx, one, one / 2, one), 0);
        send_item(make_item(0, mx, 0, one, mx, 0, 0, mx, one, one, one), 0);
        send_item(make_item(mn, mn, mn, mx, mx, mn, mn, mx, mx, 0, 0), 0);
        send_item(make_item(mx, mx, mx, mn, mn, mx, mx, mn, mn, 0, 0), 0);
        send_item(make_item(mn, 0, mn, mx, 0, mn, mn, 0, mx, mx, mx), 0);
        for (int i = 0; i < NFIELD; i++) begin
            it[i] = mx;
        end
        send_item(it, 0);
        for (int i = 0; i < NFIELD; i++) begin
            it[i] = mn;
        end
        send_item(it, 0);
        stop_sending();
    endtask

    task automatic test_random_items(int count);
        for (int n = 0; n < count; n++) begin
            send_item(random_item(), 1);
        end
        stop_sending();
    endtask

    task automatic test_margin_settings();
        write_margin(16'd0);
        test_directed();
        test_random_items(150);
        write_margin(16'hFFFF);
        test_directed();
        test_random_items(150);
        write_margin(16'($urandom));
        test_random_items(150);
        write_margin(MARGIN_RESET);
    endtask

    task automatic test_full_stall();
        wait_idle();
        hold_pop_cycles = 600;
        test_random_items(40);
    endtask

    always @(posedge i_clk) begin
        if (pop_enable) begin
            if (hold_pop_cycles > 0) begin
                hold_pop_cycles <= hold_pop_cycles - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) < 70);
            end
        end
    end

    always @(posedge i_clk) begin
        t_height_res want;
        if (pop && !empty) begin
            if (expected_heights.size() == 0) begin
                report_mismatch("unexpected word height", o_height, 0);
            end else begin
                want = expected_heights.pop_front();
                if (o_inside_res !== want.in_tri)
                    report_mismatch("inside", o_inside_res, want.in_tri);
                if (o_degenerate !== want.degen)
                    report_mismatch("degenerate", o_degenerate, want.degen);
                if (o_height !== want.height)
                    report_mismatch("height", o_height, want.height);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n || expected_heights.size() == 0
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_MAX) begin
            $display("timeout waiting for a word");
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        pop_enable = 1'b1;
        test_directed();
        test_random_items(300);
        test_margin_settings();
        test_full_stall();
        test_random_items(706);
        wait_idle();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
